// ===== hdl/stp_pkg.sv =====
// Shared constants, register indexes and tables for the slab transport step.
package stp_pkg;

  localparam logic [1:0] REG_LEFT_EDGE  = 2'd0;
  localparam logic [1:0] REG_RIGHT_EDGE = 2'd1;
  localparam logic [1:0] REG_INTERACT   = 2'd2;
  localparam logic [1:0] REG_ABSORB     = 2'd3;

  localparam logic [1:0] SIDE_STAY  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  localparam logic [31:0] LN2_Q32        = 32'hB17217F8;
  localparam logic [31:0] LOG2E_FRAC_Q32 = 32'h71547652;
  localparam logic [47:0] ACC_MAX        = 48'hFFFF_FFFF_FFFF;
  localparam logic [3:0]  TAYLOR_LAST    = 4'd12;

  // Floor of 2^32 / k for the Taylor term divisors.
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] r;
    unique case (k)
      4'd2:    r = 32'h80000000;
      4'd3:    r = 32'h55555555;
      4'd4:    r = 32'h40000000;
      4'd5:    r = 32'h33333333;
      4'd6:    r = 32'h2AAAAAAA;
      4'd7:    r = 32'h24924924;
      4'd8:    r = 32'h20000000;
      4'd9:    r = 32'h1C71C71C;
      4'd10:   r = 32'h19999999;
      4'd11:   r = 32'h1745D174;
      4'd12:   r = 32'h15555555;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/stp_ifc.sv =====
// Request and result channel interfaces of the slab transport step.
interface stp_in_if #(parameter int RANDOM_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic signed [31:0]     position;
  logic signed [15:0]     direction;
  logic [30:0]            weight;
  logic [RANDOM_BITS-1:0] rand_distance;
  logic [RANDOM_BITS-1:0] rand_direction;
  modport source(output valid, position, direction, weight, rand_distance, rand_direction,
                 input ready);
  modport sink(input valid, position, direction, weight, rand_distance, rand_direction,
               output ready);
endinterface

interface stp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_position;
  logic signed [15:0] new_direction;
  logic [30:0]        new_weight;
  logic [30:0]        deposited;
  logic [1:0]         exit_side;
  logic [47:0]        absorbed_total;
  modport source(output valid, new_position, new_direction, new_weight, deposited, exit_side,
                 absorbed_total, input ready);
  modport sink(input valid, new_position, new_direction, new_weight, deposited, exit_side,
               absorbed_total, output ready);
endinterface

// ===== hdl/stp_mul.sv =====
// Shared 32 by 32 unsigned multiplier with a registered product.
module stp_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

// ===== hdl/stp_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module stp_div #(
  parameter int NW = 38,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  assign rem_sh = {rem, quo[NW-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      dvs  <= den;
      quo  <= num;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/slab_particle_transport_step_top.sv =====
// Top level of the slab transport step: sequencer around a shared multiplier and divider.
// A request passes through normalization, the 32 squarings of the logarithm, the bit-serial
// division, the collision decision, the move after an interior collision, the exponent, the
// eleven Taylor steps and the deposit. A large absorption exponent skips the series.
// One request is in work at a time: the next is accepted only after the last result has
// entered the output register, which waits while an earlier result is not yet taken.
// Synchronous reset sets the configuration registers to their defaults and the total to zero.
module slab_particle_transport_step_top #(
  parameter int RANDOM_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  stp_in_if.sink      req_ch,
  stp_out_if.source   res_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_SQM, S_SQU, S_LNH, S_LNL, S_DIVS, S_DIVW, S_DEC, S_MOVE,
    S_XM, S_XG, S_YH, S_YL, S_TM, S_TG, S_TA, S_TB, S_TC, S_TD, S_EXP,
    S_DEPM, S_DEPG, S_DONE
  } state_t;

  state_t state;

  logic signed [31:0] left_edge, right_edge;
  logic [31:0]        irate, arate;
  logic [47:0]        acc;

  logic signed [31:0]     pos;
  logic signed [15:0]     dir;
  logic [30:0]            wgt;
  logic [RANDOM_BITS:0]   hnum;
  logic [RANDOM_BITS-1:0] vr;
  logic [31:0]            m;
  logic [31:0]            frac;
  logic [4:0]             cnt;
  logic [5:0]             kk;
  logic                   left;
  logic signed [31:0]     edge_pos;
  logic [32:0]            ed;
  logic [37:0]            lnhi;
  logic [31:0]            path;
  logic [31:0]            newpos;
  logic [15:0]            newdir;
  logic [1:0]             side;
  logic [63:0]            x;
  logic [36:0]            yhi;
  logic [37:0]            y;
  logic [31:0]            t, term, pr, q0;
  logic [33:0]            tsum;
  logic [3:0]             kc;
  logic [32:0]            e;
  logic [30:0]            dw;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        div_start, div_done;
  logic [37:0] div_num, div_q;

  logic [5:0]              k_lead;
  logic [RANDOM_BITS+31:0] norm_sh;
  logic [37:0]             lval;
  logic [32:0]             sq;
  logic [15:0]             mag;
  logic                    ed_pos;
  logic                    coll;
  logic [31:0]             move;
  logic [31:0]             rdiff;
  logic [31:0]             qk;
  logic [32:0]             om;
  logic [48:0]             acc_sum;
  logic [15:0]             vtop;

  stp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  stp_div #(.NW(38), .DW(32)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(irate),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    k_lead = '0;
    for (int i = 0; i <= RANDOM_BITS; i++) begin
      if (hnum[i]) k_lead = 6'(i);
    end
  end

  assign norm_sh = {hnum, 31'b0} >> k_lead;
  assign lval    = {6'(RANDOM_BITS) - kk, 32'b0} - {6'b0, frac};
  assign sq      = mul_p[63:31];
  assign mag     = left ? 16'(-dir) : 16'(dir);
  assign ed_pos  = !ed[32] && (ed != '0);
  assign coll    = ed_pos && (irate != '0) && (div_q < {5'b0, ed});
  assign move    = mul_p[46:15];
  assign rdiff   = pr - mul_p[31:0];
  assign qk      = (rdiff >= {28'b0, kc}) ? q0 + 1'b1 : q0;
  assign om      = 33'h1_0000_0000 - e;
  assign acc_sum = {1'b0, acc} + 49'(dw);
  assign div_num = lnhi + {6'b0, mul_p[63:32]};
  assign div_start = (state == S_DIVS);
  assign vtop    = vr[RANDOM_BITS-1 -: 16];
  assign req_ch.ready = (state == S_IDLE);

  always_comb begin
    mul_a = m;
    mul_b = m;
    unique case (state)
      S_LNH:  begin mul_a = {26'b0, lval[37:32]}; mul_b = stp_pkg::LN2_Q32; end
      S_LNL:  begin mul_a = lval[31:0];           mul_b = stp_pkg::LN2_Q32; end
      S_DEC:  begin mul_a = div_q[31:0];          mul_b = {16'b0, mag}; end
      S_XM:   begin mul_a = path;                 mul_b = arate; end
      S_XG:   begin mul_a = {27'b0, mul_p[36:32]}; mul_b = stp_pkg::LOG2E_FRAC_Q32; end
      S_YH:   begin mul_a = x[31:0];              mul_b = stp_pkg::LOG2E_FRAC_Q32; end
      S_TM:   begin mul_a = y[31:0];              mul_b = stp_pkg::LN2_Q32; end
      S_TA:   begin mul_a = term;                 mul_b = t; end
      S_TB:   begin mul_a = mul_p[63:32];         mul_b = stp_pkg::recip(kc); end
      S_TC:   begin mul_a = mul_p[63:32];         mul_b = {28'b0, kc}; end
      S_DEPM: begin mul_a = om[31:0];             mul_b = {1'b0, wgt}; end
      default: begin mul_a = m; mul_b = m; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      left_edge  <= 32'sd0;
      right_edge <= 32'sd65536;
      irate      <= 32'd65536;
      arate      <= 32'd65536;
      acc        <= '0;
      res_ch.valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          stp_pkg::REG_LEFT_EDGE:  left_edge  <= cfg_data;
          stp_pkg::REG_RIGHT_EDGE: right_edge <= cfg_data;
          stp_pkg::REG_INTERACT:   irate      <= cfg_data;
          stp_pkg::REG_ABSORB:     arate      <= cfg_data;
        endcase
      end
      if (res_ch.valid && res_ch.ready && state != S_DONE) res_ch.valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (req_ch.valid) begin
            pos   <= req_ch.position;
            dir   <= req_ch.direction;
            wgt   <= req_ch.weight;
            hnum  <= {1'b1, {RANDOM_BITS{1'b0}}} - {1'b0, req_ch.rand_distance};
            vr    <= req_ch.rand_direction;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          kk       <= k_lead;
          m        <= norm_sh[31:0];
          frac     <= '0;
          cnt      <= '0;
          left     <= dir[15];
          edge_pos <= dir[15] ? left_edge : right_edge;
          ed       <= dir[15] ? {pos[31], pos} - {left_edge[31], left_edge}
                              : {right_edge[31], right_edge} - {pos[31], pos};
          state    <= S_SQM;
        end
        S_SQM: state <= S_SQU;
        S_SQU: begin
          if (sq[32]) begin
            m    <= sq[32:1];
            frac <= {frac[30:0], 1'b1};
          end else begin
            m    <= sq[31:0];
            frac <= {frac[30:0], 1'b0};
          end
          cnt   <= cnt + 1'b1;
          state <= (cnt == 5'd31) ? S_LNH : S_SQM;
        end
        S_LNH: state <= S_LNL;
        S_LNL: begin
          lnhi  <= mul_p[37:0];
          state <= S_DIVS;
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: if (div_done) state <= S_DEC;
        S_DEC: begin
          if (coll) begin
            path   <= div_q[31:0];
            newdir <= {~vtop[15], vtop[14:0]};
            side   <= stp_pkg::SIDE_STAY;
            state  <= S_MOVE;
          end else begin
            path   <= ed_pos ? ed[31:0] : 32'd0;
            newpos <= edge_pos;
            newdir <= dir;
            side   <= left ? stp_pkg::SIDE_LEFT : stp_pkg::SIDE_RIGHT;
            state  <= S_XM;
          end
        end
        S_MOVE: begin
          newpos <= left ? pos - move : pos + move;
          state  <= S_XM;
        end
        S_XM: state <= S_XG;
        S_XG: begin
          x <= mul_p;
          if (mul_p[63:37] != '0) begin
            e     <= '0;
            state <= S_DEPM;
          end else begin
            state <= S_YH;
          end
        end
        S_YH: begin
          yhi   <= mul_p[36:0];
          state <= S_YL;
        end
        S_YL: begin
          y     <= x[37:0] + {1'b0, yhi} + {6'b0, mul_p[63:32]};
          state <= S_TM;
        end
        S_TM: state <= S_TG;
        S_TG: begin
          t     <= mul_p[63:32];
          term  <= mul_p[63:32];
          tsum  <= 34'h1_0000_0000 - {2'b0, mul_p[63:32]};
          kc    <= 4'd2;
          state <= S_TA;
        end
        S_TA: state <= S_TB;
        S_TB: begin
          pr    <= mul_p[63:32];
          state <= S_TC;
        end
        S_TC: begin
          q0    <= mul_p[63:32];
          state <= S_TD;
        end
        S_TD: begin
          term <= qk;
          tsum <= kc[0] ? tsum - {2'b0, qk} : tsum + {2'b0, qk};
          kc   <= kc + 1'b1;
          state <= (kc == stp_pkg::TAYLOR_LAST) ? S_EXP : S_TA;
        end
        S_EXP: begin
          e     <= 33'(tsum >> y[37:32]);
          state <= S_DEPM;
        end
        S_DEPM: state <= S_DEPG;
        S_DEPG: begin
          dw    <= om[32] ? wgt : mul_p[62:32];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_ch.valid || res_ch.ready) begin
            acc                  <= acc_sum[48] ? stp_pkg::ACC_MAX : acc_sum[47:0];
            res_ch.valid         <= 1'b1;
            res_ch.new_position  <= newpos;
            res_ch.new_direction <= newdir;
            res_ch.new_weight    <= wgt - dw;
            res_ch.deposited     <= dw;
            res_ch.exit_side     <= side;
            res_ch.absorbed_total <= acc_sum[48] ? stp_pkg::ACC_MAX : acc_sum[47:0];
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_ch.valid && req_ch.ready) |=> state == S_NORM)
    else $error("accepted request did not start normalization");

  a_side_code: assert property (@(posedge clk) disable iff (rst)
    res_ch.valid |-> res_ch.exit_side != 2'd3)
    else $error("invalid exit side on result");

  a_acc_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!res_ch.valid || res_ch.ready)) |=> acc >= $past(acc))
    else $error("absorbed total decreased");

  a_stay_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC && coll) |-> (div_q[37:32] == '0))
    else $error("interior path exceeds 32 bits");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the slab transport step: directed table, random phases, predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RB = 24;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [15:0] dir;
    logic [30:0]        wt;
    logic [RB-1:0]      ud;
    logic [RB-1:0]      vd;
  } particle_t;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [15:0] dir;
    logic [30:0]        wt;
    logic [30:0]        dep;
    logic [1:0]         side;
    logic [47:0]        total;
  } step_t;

  typedef struct {
    particle_t p;
    bit        typed;
    step_t     r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = stp_pkg::REG_LEFT_EDGE;
  logic [31:0] cfg_data = '0;

  stp_in_if #(.RANDOM_BITS(RB)) req_ch();
  stp_out_if res_ch();

  slab_particle_transport_step_top #(.RANDOM_BITS(RB)) i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_ch(req_ch.sink), .res_ch(res_ch.source)
  );

  always #2 clk = ~clk;

  logic [31:0] left_edge_q = 32'd0;
  logic [31:0] right_edge_q = 32'h10000;
  logic [31:0] interact_q = 32'h10000;
  logic [31:0] absorb_q = 32'h10000;
  logic [47:0] absorbed_sum = '0;

  step_t pending_steps[$];
  row_t rows[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;

  function automatic logic [63:0] mul_frac(logic [63:0] a, logic [63:0] c);
    return (a >> 32) * c + (((a & 64'hFFFF_FFFF) * c) >> 32);
  endfunction

  // Negative natural log of h / 2^RB in Q.32.
  function automatic logic [63:0] neg_log(logic [63:0] h);
    int k;
    logic [63:0] m;
    logic [63:0] frac;
    k = 0;
    frac = '0;
    while (k < 40 && (h >> (k + 1)) != 0) k++;
    m = (k <= 31) ? (h << (31 - k)) : (h >> (k - 31));
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return mul_frac(((64'(RB) - 64'(k)) << 32) - frac, 64'(stp_pkg::LN2_Q32));
  endfunction

  function automatic logic [63:0] exp_decay(logic [63:0] x);
    logic [63:0] y, t, term, sum, n;
    if ((x >> 32) >= 32) return 64'd0;
    y = x + mul_frac(x, 64'(stp_pkg::LOG2E_FRAC_Q32));
    n = y >> 32;
    t = ((y & 64'hFFFF_FFFF) * 64'(stp_pkg::LN2_Q32)) >> 32;
    term = 64'h1_0000_0000;
    sum = 64'h1_0000_0000;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * t) >> 32) / 64'(k);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return (n >= 63) ? 64'd0 : (sum >> n);
  endfunction

  function automatic step_t transport(particle_t p);
    step_t r;
    bit left;
    longint pos, edge_pos, edge_dist, move;
    logic [63:0] path, mag, e, dw, free_path, hnum;
    logic [64:0] total;
    left = p.dir < 0;
    pos = longint'(p.pos);
    edge_pos = left ? longint'($signed(left_edge_q)) : longint'($signed(right_edge_q));
    edge_dist = left ? pos - edge_pos : edge_pos - pos;
    hnum = (64'd1 << RB) - 64'(p.ud);
    free_path = (interact_q != 0) ? neg_log(hnum) / 64'(interact_q) : '0;
    r.dir = p.dir;
    if (edge_dist > 0 && interact_q != 0 && free_path < 64'(edge_dist)) begin
      path = free_path;
      mag = left ? 64'(-longint'(p.dir)) : 64'(longint'(p.dir));
      move = longint'((path * mag) >> 15);
      r.pos = 32'(left ? pos - move : pos + move);
      r.dir = 16'((64'(p.vd) >> (RB - 16)) - 64'd32768);
      r.side = stp_pkg::SIDE_STAY;
    end else begin
      path = (edge_dist > 0) ? 64'(edge_dist) : 64'd0;
      r.pos = 32'(edge_pos);
      r.side = left ? stp_pkg::SIDE_LEFT : stp_pkg::SIDE_RIGHT;
    end
    e = exp_decay(path * 64'(absorb_q));
    dw = (64'(p.wt) * (64'h1_0000_0000 - e)) >> 32;
    total = 65'(absorbed_sum) + 65'(dw);
    absorbed_sum = (total > 65'(stp_pkg::ACC_MAX)) ? stp_pkg::ACC_MAX : total[47:0];
    r.wt = 31'(64'(p.wt) - dw);
    r.dep = 31'(dw);
    r.total = absorbed_sum;
    return r;
  endfunction

  task automatic add_row(particle_t p, bit typed, step_t r);
    row_t n;
    n.p = p;
    n.typed = typed;
    n.r = r;
    rows.insert(rows.size(), n);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    case (idx)
      stp_pkg::REG_LEFT_EDGE:  left_edge_q = data;
      stp_pkg::REG_RIGHT_EDGE: right_edge_q = data;
      stp_pkg::REG_INTERACT:   interact_q = data;
      default:                 absorb_q = data;
    endcase
  endtask

  task automatic configure(logic [31:0] l, logic [31:0] r, logic [31:0] si, logic [31:0] sa);
    write_reg(stp_pkg::REG_LEFT_EDGE, l);
    write_reg(stp_pkg::REG_RIGHT_EDGE, r);
    write_reg(stp_pkg::REG_INTERACT, si);
    write_reg(stp_pkg::REG_ABSORB, sa);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic offer(particle_t p, bit typed, step_t want);
    step_t predicted;
    int g;
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.position = p.pos;
    req_ch.direction = p.dir;
    req_ch.weight = p.wt;
    req_ch.rand_distance = p.ud;
    req_ch.rand_direction = p.vd;
    do @(posedge clk); while (!req_ch.ready);
    predicted = transport(p);
    pending_steps.insert(pending_steps.size(), typed ? want : predicted);
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
  endtask

  task automatic drain();
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic particle_t random_particle();
    particle_t p;
    longint l, r;
    int k;
    l = longint'($signed(left_edge_q));
    r = longint'($signed(right_edge_q));
    k = $urandom_range(0, 99);
    if (k < 80 && r > l)
      p.pos = 32'(l + longint'({$urandom, $urandom} % 64'(r - l + 1)));
    else
      p.pos = $urandom;
    k = $urandom_range(0, 9);
    p.dir = (k == 0) ? 16'sh7FFF : (k == 1) ? -16'sh8000 : (k == 2) ? 16'sd0 : 16'($urandom);
    p.wt = (k == 3) ? 31'h4000_0000 : 31'($urandom_range(0, 32'h4000_0000));
    p.ud = (k == 4) ? {RB{1'b1}} : RB'($urandom);
    p.vd = RB'($urandom);
    return p;
  endfunction

  initial begin
    req_ch.valid = 1'b0;
    req_ch.position = '0;
    req_ch.direction = '0;
    req_ch.weight = '0;
    req_ch.rand_distance = '0;
    req_ch.rand_direction = '0;
  end

  // Output side: random back-pressure with an occasional long hold-off.
  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready = 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 2000;
        res_ch.ready = 1'b0;
      end else if (no_idle) begin
        res_ch.ready = 1'b1;
      end else begin
        res_ch.ready = (gap_len() == 0);
      end
    end
  end

  always @(posedge clk) begin
    step_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected result: new_position %h", res_ch.new_position);
        errors++;
      end else begin
        w = pending_steps.pop_front();
        if (res_ch.new_position !== w.pos) begin
          $error("new_position expected %h actual %h", w.pos, res_ch.new_position);
          errors++;
        end
        if (res_ch.new_direction !== w.dir) begin
          $error("new_direction expected %h actual %h", w.dir, res_ch.new_direction);
          errors++;
        end
        if (res_ch.new_weight !== w.wt) begin
          $error("new_weight expected %h actual %h", w.wt, res_ch.new_weight);
          errors++;
        end
        if (res_ch.deposited !== w.dep) begin
          $error("deposited expected %h actual %h", w.dep, res_ch.deposited);
          errors++;
        end
        if (res_ch.exit_side !== w.side) begin
          $error("exit_side expected %h actual %h", w.side, res_ch.exit_side);
          errors++;
        end
        if (res_ch.absorbed_total !== w.total) begin
          $error("absorbed_total expected %h actual %h", w.total, res_ch.absorbed_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL slab_particle_transport_step_top");
      $finish;
    end
  end

  initial begin
    particle_t p;
    step_t none;
    none = '{pos: '0, dir: '0, wt: '0, dep: '0, side: stp_pkg::SIDE_STAY, total: '0};

    // Particles outside or on the edge of the default cell leave at once and deposit nothing.
    add_row('{32'sh20000, 16'sh4000, 31'h4000_0000, 24'h123456, 24'h0}, 1'b1,
            '{32'sh10000, 16'sh4000, 31'h4000_0000, 31'd0, stp_pkg::SIDE_RIGHT, 48'd0});
    add_row('{-32'sh10000, -16'sh8000, 31'h2000_0000, 24'h0, 24'hFFFFFF}, 1'b1,
            '{32'sh0, -16'sh8000, 31'h2000_0000, 31'd0, stp_pkg::SIDE_LEFT, 48'd0});
    add_row('{32'sh10000, 16'sh0, 31'h7FFF_FFFF, 24'hFFFFFF, 24'h0}, 1'b1,
            '{32'sh10000, 16'sh0, 31'h7FFF_FFFF, 31'd0, stp_pkg::SIDE_RIGHT, 48'd0});
    add_row('{32'sh0, -16'sh1, 31'h1, 24'h800000, 24'h800000}, 1'b1,
            '{32'sh0, -16'sh1, 31'h1, 31'd0, stp_pkg::SIDE_LEFT, 48'd0});
    add_row('{32'sh7FFF_FFFF, 16'sh7FFF, 31'h4000_0000, 24'h0, 24'h0}, 1'b1,
            '{32'sh10000, 16'sh7FFF, 31'h4000_0000, 31'd0, stp_pkg::SIDE_RIGHT, 48'd0});
    add_row('{-32'sh8000_0000, -16'sh8000, 31'h0, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
            '{32'sh0, -16'sh8000, 31'h0, 31'd0, stp_pkg::SIDE_LEFT, 48'd0});
    // Inside the cell or on its edge moving inward: extremes of the samples, direction and weight.
    add_row('{32'sh8000, 16'sh7FFF, 31'h4000_0000, 24'h0, 24'h0}, 1'b0, none);
    add_row('{32'sh8000, -16'sh8000, 31'h4000_0000, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, none);
    add_row('{32'sh8000, 16'sh0, 31'h4000_0000, 24'h000001, 24'h7FFFFF}, 1'b0, none);
    add_row('{32'sh1, -16'sh1, 31'h0, 24'h800000, 24'h000100}, 1'b0, none);
    add_row('{32'shFFFF, 16'sh1, 31'h7FFF_FFFF, 24'hF00000, 24'hFFFF00}, 1'b0, none);
    add_row('{32'sh0, 16'sh7FFF, 31'h3FFF_FFFF, 24'h000010, 24'h0000FF}, 1'b0, none);
    add_row('{32'sh10000, -16'sh4000, 31'h1234_5678, 24'h400000, 24'hABCDEF}, 1'b0, none);
    add_row('{32'sh4000, -16'sh7FFF, 31'h4000_0000, 24'hFFFFF0, 24'h555555}, 1'b0, none);
    add_row('{32'shC000, 16'sh2000, 31'h2AAA_AAAA, 24'hAAAAAA, 24'h333333}, 1'b0, none);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) offer(rows[i].p, rows[i].typed, rows[i].r);
    @(negedge clk);
    req_ch.valid = 1'b0;
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: configure(32'h0, 32'h40000, 32'h0, 32'h8000);
        1: configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: configure(32'hFFFF_0000, 32'h10000, 32'h1, 32'h0);
        3: configure(32'h0, 32'h10000, 32'h10000, 32'h0100_0000);
        default: begin
          longint l, w;
          l = longint'($urandom_range(0, 32'h0100_0000)) - 64'sh80_0000;
          w = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(1, 32'h4000_0000))
                                          : longint'($urandom_range(1, 32'h8_0000));
          configure(32'(l), 32'(l + w),
                    ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(32'h100, 32'h8_0000),
                    ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h8_0000));
        end
      endcase
      no_idle = (phase == 4);
      hold_request = (phase == 5);
      repeat (100) begin
        p = random_particle();
        offer(p, 1'b0, none);
      end
      @(negedge clk);
      req_ch.valid = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("PASS slab_particle_transport_step_top");
    end else begin
      $display("FAIL slab_particle_transport_step_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/stp_pkg.sv
hdl/stp_ifc.sv
hdl/stp_mul.sv
hdl/stp_div.sv
hdl/slab_particle_transport_step_top.sv
sim/tb_top.sv
